FILE: rtl/core/sckt_pkg.sv
// Shared constants, scancode tables and ring pointer helpers for the scancode translator.
package sckt_pkg;

  localparam int RING_DEPTH = 256;
  localparam int PTR_W      = $clog2(RING_DEPTH);

  localparam logic [PTR_W-1:0] RING_LAST = PTR_W'(RING_DEPTH - 1);

  localparam logic [1:0] KIND_APP   = 2'd0;
  localparam logic [1:0] KIND_FOCUS = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [7:0] SC_EXT_PREFIX = 8'hE0;
  localparam logic [7:0] SC_LSHIFT     = 8'h2A;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_CTRL       = 8'h1D;
  localparam logic [7:0] SC_ALT        = 8'h38;
  localparam logic [7:0] SC_CAPS       = 8'h3A;
  localparam logic [7:0] SC_TAB        = 8'h0F;
  localparam logic [7:0] SC_T          = 8'h14;
  localparam logic [7:0] KEY_ALT_TAB   = 8'h88;
  localparam logic [7:0] CASE_OFFSET   = 8'd32;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == RING_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // US layout, no shift
  function automatic logic [7:0] map_plain(input logic [5:0] sc);
    logic [7:0] c;
    case (sc)
      6'd1:  c = 8'h1B;
      6'd2:  c = 8'h31;
      6'd3:  c = 8'h32;
      6'd4:  c = 8'h33;
      6'd5:  c = 8'h34;
      6'd6:  c = 8'h35;
      6'd7:  c = 8'h36;
      6'd8:  c = 8'h37;
      6'd9:  c = 8'h38;
      6'd10: c = 8'h39;
      6'd11: c = 8'h30;
      6'd12: c = 8'h2D;
      6'd13: c = 8'h3D;
      6'd14: c = 8'h08;
      6'd15: c = 8'h09;
      6'd16: c = 8'h71;
      6'd17: c = 8'h77;
      6'd18: c = 8'h65;
      6'd19: c = 8'h72;
      6'd20: c = 8'h74;
      6'd21: c = 8'h79;
      6'd22: c = 8'h75;
      6'd23: c = 8'h69;
      6'd24: c = 8'h6F;
      6'd25: c = 8'h70;
      6'd26: c = 8'h5B;
      6'd27: c = 8'h5D;
      6'd28: c = 8'h0A;
      6'd30: c = 8'h61;
      6'd31: c = 8'h73;
      6'd32: c = 8'h64;
      6'd33: c = 8'h66;
      6'd34: c = 8'h67;
      6'd35: c = 8'h68;
      6'd36: c = 8'h6A;
      6'd37: c = 8'h6B;
      6'd38: c = 8'h6C;
      6'd39: c = 8'h3B;
      6'd40: c = 8'h27;
      6'd41: c = 8'h60;
      6'd43: c = 8'h5C;
      6'd44: c = 8'h7A;
      6'd45: c = 8'h78;
      6'd46: c = 8'h63;
      6'd47: c = 8'h76;
      6'd48: c = 8'h62;
      6'd49: c = 8'h6E;
      6'd50: c = 8'h6D;
      6'd51: c = 8'h2C;
      6'd52: c = 8'h2E;
      6'd53: c = 8'h2F;
      6'd55: c = 8'h2A;
      6'd57: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // US layout, shift held
  function automatic logic [7:0] map_shift(input logic [5:0] sc);
    logic [7:0] c;
    case (sc)
      6'd1:  c = 8'h1B;
      6'd2:  c = 8'h21;
      6'd3:  c = 8'h40;
      6'd4:  c = 8'h23;
      6'd5:  c = 8'h24;
      6'd6:  c = 8'h25;
      6'd7:  c = 8'h5E;
      6'd8:  c = 8'h26;
      6'd9:  c = 8'h2A;
      6'd10: c = 8'h28;
      6'd11: c = 8'h29;
      6'd12: c = 8'h5F;
      6'd13: c = 8'h2B;
      6'd14: c = 8'h08;
      6'd15: c = 8'h09;
      6'd16: c = 8'h51;
      6'd17: c = 8'h57;
      6'd18: c = 8'h45;
      6'd19: c = 8'h52;
      6'd20: c = 8'h54;
      6'd21: c = 8'h59;
      6'd22: c = 8'h55;
      6'd23: c = 8'h49;
      6'd24: c = 8'h4F;
      6'd25: c = 8'h50;
      6'd26: c = 8'h7B;
      6'd27: c = 8'h7D;
      6'd28: c = 8'h0A;
      6'd30: c = 8'h41;
      6'd31: c = 8'h53;
      6'd32: c = 8'h44;
      6'd33: c = 8'h46;
      6'd34: c = 8'h47;
      6'd35: c = 8'h48;
      6'd36: c = 8'h4A;
      6'd37: c = 8'h4B;
      6'd38: c = 8'h4C;
      6'd39: c = 8'h3A;
      6'd40: c = 8'h22;
      6'd41: c = 8'h7E;
      6'd43: c = 8'h7C;
      6'd44: c = 8'h5A;
      6'd45: c = 8'h58;
      6'd46: c = 8'h43;
      6'd47: c = 8'h56;
      6'd48: c = 8'h42;
      6'd49: c = 8'h4E;
      6'd50: c = 8'h4D;
      6'd51: c = 8'h3C;
      6'd52: c = 8'h3E;
      6'd53: c = 8'h3F;
      6'd55: c = 8'h2A;
      6'd57: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // E0-prefixed make codes: arrows, Del, Home, End, keypad Enter, '/', '+'
  function automatic logic [7:0] map_extended(input logic [7:0] sc);
    logic [7:0] c;
    case (sc)
      8'h48:   c = 8'h81;
      8'h50:   c = 8'h82;
      8'h4B:   c = 8'h83;
      8'h4D:   c = 8'h84;
      8'h53:   c = 8'h85;
      8'h47:   c = 8'h86;
      8'h4F:   c = 8'h87;
      8'h1C:   c = 8'h0A;
      8'h35:   c = 8'h2F;
      8'h4E:   c = 8'h2B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/scancode_to_key_translator_core.sv
// Top level: scancode set 1 translator with modifier tracking and a shell key ring.
//
// Takes one beat per clock when the result side keeps up: a scancode byte or a
// read request is decoded in the cycle it is accepted, the shell ring (a
// RING_DEPTH x 8 synchronous memory, one write or one read per beat) is updated
// in that same cycle, and a result leaves through the registered read-data
// stage and an output register. Scancode beats that only change modifier state
// or push into the ring produce no result beat. The ring holds RING_DEPTH-1 keys
// and drops new keys while full. A read beat always yields one reply, with
// read_hit low on an empty ring. Input stall rises only when both result stages
// are full and the output is stalled. gui_mode is written through the cfg port,
// which is always ready; write it only while no beat is in flight.
module scancode_to_key_translator_core
  import sckt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [7:0] in_scan_byte,
  input  logic       in_switcher_open,
  input  logic       in_terminal_focused,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_key_code,
  output logic       out_read_hit,
  output logic       out_ring_not_empty
);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] code;
    logic       hit;
    logic       not_empty;
    logic       from_mem;
  } res_t;

  // control state
  logic             gui_mode_r;
  logic             shift_r, shift_nxt;
  logic             caps_r, caps_nxt;
  logic             ctrl_r, ctrl_nxt;
  logic             alt_r, alt_nxt;
  logic             ext_r, ext_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;

  // ring memory
  logic [7:0]       ring_mem [RING_DEPTH];
  logic [7:0]       ring_q_r;
  logic             ring_we;
  logic             ring_re;
  logic [7:0]       ring_wdata;

  // result stages
  logic             s1_valid_r;
  res_t             s1_r;
  logic             s1_adv;
  logic             out_valid_r;
  logic [1:0]       out_kind_r;
  logic [7:0]       out_key_code_r;
  logic             out_read_hit_r;
  logic             out_ring_not_empty_r;

  // decode
  logic             accept;
  logic             res_valid;
  res_t             res;
  logic             do_route;
  logic [7:0]       route_code;
  logic             to_app;
  logic [7:0]       tbl_code;
  logic [7:0]       case_code;
  logic [7:0]       key_code;
  logic [6:0]       brk_code;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign accept    = in_valid && !in_stall;
  assign brk_code  = in_scan_byte[6:0];
  assign to_app    = gui_mode_r && (in_switcher_open || !in_terminal_focused);

  // plain key path: table, caps, ctrl
  always_comb begin
    tbl_code = (in_scan_byte[7:6] == 2'b00)
             ? (shift_r ? map_shift(in_scan_byte[5:0]) : map_plain(in_scan_byte[5:0]))
             : 8'h00;
    case_code = tbl_code;
    if (caps_r && (tbl_code inside {[8'h61:8'h7A]})) begin
      case_code = tbl_code - CASE_OFFSET;
    end else if (caps_r && shift_r && (tbl_code inside {[8'h41:8'h5A]})) begin
      case_code = tbl_code + CASE_OFFSET;
    end
    key_code = case_code;
    if (ctrl_r && (case_code inside {[8'h61:8'h7A], [8'h41:8'h5A]})) begin
      key_code = {3'b000, case_code[4:0]};
    end
  end

  always_comb begin
    shift_nxt  = shift_r;
    caps_nxt   = caps_r;
    ctrl_nxt   = ctrl_r;
    alt_nxt    = alt_r;
    ext_nxt    = ext_r;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    ring_we    = 1'b0;
    ring_re    = 1'b0;
    ring_wdata = 8'h00;
    res_valid  = 1'b0;
    res        = '0;
    do_route   = 1'b0;
    route_code = 8'h00;

    if (accept) begin
      if (in_action) begin
        res_valid = 1'b1;
        res.kind  = KIND_READ;
        if (wr_ptr_r != rd_ptr_r) begin
          ring_re      = 1'b1;
          rd_ptr_nxt   = ptr_next(rd_ptr_r);
          res.hit      = 1'b1;
          res.from_mem = 1'b1;
        end
        res.not_empty = (wr_ptr_r != rd_ptr_nxt);
      end else if (ext_r) begin
        ext_nxt = 1'b0;
        if (!in_scan_byte[7] && (map_extended(in_scan_byte) != 8'h00)) begin
          do_route   = 1'b1;
          route_code = map_extended(in_scan_byte);
        end
      end else if (in_scan_byte == SC_EXT_PREFIX) begin
        ext_nxt = 1'b1;
      end else if (in_scan_byte[7]) begin
        // break code: release the matching modifier
        if (brk_code == SC_LSHIFT[6:0] || brk_code == SC_RSHIFT[6:0]) begin
          shift_nxt = 1'b0;
        end else if (brk_code == SC_CTRL[6:0]) begin
          ctrl_nxt = 1'b0;
        end else if (brk_code == SC_ALT[6:0]) begin
          alt_nxt = 1'b0;
        end
      end else if (in_scan_byte == SC_LSHIFT || in_scan_byte == SC_RSHIFT) begin
        shift_nxt = 1'b1;
      end else if (in_scan_byte == SC_CTRL) begin
        ctrl_nxt = 1'b1;
      end else if (in_scan_byte == SC_ALT) begin
        alt_nxt = 1'b1;
      end else if (in_scan_byte == SC_TAB && alt_r) begin
        do_route   = 1'b1;
        route_code = KEY_ALT_TAB;
      end else if (in_scan_byte == SC_T && alt_r) begin
        res_valid     = 1'b1;
        res.kind      = KIND_FOCUS;
        res.not_empty = (wr_ptr_r != rd_ptr_r);
      end else if (in_scan_byte == SC_CAPS) begin
        caps_nxt = !caps_r;
      end else if (case_code != 8'h00) begin
        do_route   = 1'b1;
        route_code = key_code;
      end

      if (do_route) begin
        if (to_app) begin
          res_valid     = 1'b1;
          res.kind      = KIND_APP;
          res.code      = route_code;
          res.not_empty = (wr_ptr_r != rd_ptr_r);
        end else if (ptr_next(wr_ptr_r) != rd_ptr_r) begin
          // push into the ring; a full ring drops the key
          ring_we    = 1'b1;
          ring_wdata = route_code;
          wr_ptr_nxt = ptr_next(wr_ptr_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wr_ptr_r] <= ring_wdata;
    end
    if (ring_re) begin
      ring_q_r <= ring_mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gui_mode_r  <= 1'b0;
      shift_r     <= 1'b0;
      caps_r      <= 1'b0;
      ctrl_r      <= 1'b0;
      alt_r       <= 1'b0;
      ext_r       <= 1'b0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gui_mode_r <= cfg_data;
      end
      shift_r  <= shift_nxt;
      caps_r   <= caps_nxt;
      ctrl_r   <= ctrl_nxt;
      alt_r    <= alt_nxt;
      ext_r    <= ext_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      if (accept) begin
        s1_valid_r <= res_valid;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload stages: s1 waits for ring read data, output holds under stall
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= res;
    end
    if (s1_adv) begin
      out_kind_r           <= s1_r.kind;
      out_key_code_r       <= s1_r.from_mem ? ring_q_r : s1_r.code;
      out_read_hit_r       <= s1_r.hit;
      out_ring_not_empty_r <= s1_r.not_empty;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_key_code       = out_key_code_r;
  assign out_read_hit       = out_read_hit_r;
  assign out_ring_not_empty = out_ring_not_empty_r;

  a_read_hits_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action && (wr_ptr_r != rd_ptr_r)) |=> (s1_valid_r && s1_r.from_mem))
    else $error("read beat on non-empty ring did not reach read-data stage");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    ring_we |-> (ptr_next(wr_ptr_r) != rd_ptr_r))
    else $error("ring write while full");

  a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(ring_we && ring_re))
    else $error("ring write and read in the same beat");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=>
      (s1_valid_r && $stable(s1_r) && (!s1_r.from_mem || $stable(ring_q_r))))
    else $error("stalled read-data stage changed");

endmodule

FILE: test/tb_scancode_to_key_translator_core.sv
// Self-checking testbench for the scancode set 1 translator with its shell key ring.
module tb_scancode_to_key_translator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sckt_pkg::*;

  localparam logic       ACT_SCAN   = 1'b0;
  localparam logic       ACT_READ   = 1'b1;
  localparam logic [7:0] BREAK_FLAG = 8'h80;
  localparam int         IDLE_MAX   = 5;
  localparam int         SETTLE     = 8;

  typedef struct packed {
    logic       action;
    logic [7:0] scan_byte;
    logic       switcher_open;
    logic       terminal_focused;
  } scan_beat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] key_code;
    logic       read_hit;
    logic       ring_not_empty;
  } key_event_t;

  logic       clk = 1'b1;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_action = 1'b0;
  logic [7:0] in_scan_byte = 8'h00;
  logic       in_switcher_open = 1'b0;
  logic       in_terminal_focused = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_key_code;
  logic       out_read_hit;
  logic       out_ring_not_empty;

  scancode_to_key_translator_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_scan_byte       (in_scan_byte),
    .in_switcher_open   (in_switcher_open),
    .in_terminal_focused(in_terminal_focused),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_key_code       (out_key_code),
    .out_read_hit       (out_read_hit),
    .out_ring_not_empty (out_ring_not_empty)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  scan_beat_t pending_scans[$];
  key_event_t events_due[$];
  int         idle_max = IDLE_MAX;
  int         send_wait = 0;
  int         recv_wait = 0;
  bit         hold_out = 1'b0;
  bit         in_fired = 1'b0;
  bit         out_fired = 1'b0;
  int         mismatches = 0;
  int         beats_taken = 0;
  int         events_seen = 0;
  int         app_keys = 0;
  int         focus_events = 0;
  int         read_hits = 0;
  int         read_misses = 0;
  int         keys_dropped = 0;
  int         planned = 0;

  // Mirror of the translator state
  bit         gui_on, shift_down, ctrl_down, alt_down, caps_lit, ext_armed;
  logic [7:0] ring_copy [RING_DEPTH];
  int         wr_ptr, rd_ptr;

  // {plain, shifted} character for each set 1 make code of the US layout
  function automatic logic [15:0] us_key_pair(input logic [5:0] sc);
    case (sc)
      6'd1:  return 16'h1B1B;
      6'd2:  return 16'h3121;
      6'd3:  return 16'h3240;
      6'd4:  return 16'h3323;
      6'd5:  return 16'h3424;
      6'd6:  return 16'h3525;
      6'd7:  return 16'h365E;
      6'd8:  return 16'h3726;
      6'd9:  return 16'h382A;
      6'd10: return 16'h3928;
      6'd11: return 16'h3029;
      6'd12: return 16'h2D5F;
      6'd13: return 16'h3D2B;
      6'd14: return 16'h0808;
      6'd15: return 16'h0909;
      6'd16: return 16'h7151;
      6'd17: return 16'h7757;
      6'd18: return 16'h6545;
      6'd19: return 16'h7252;
      6'd20: return 16'h7454;
      6'd21: return 16'h7959;
      6'd22: return 16'h7555;
      6'd23: return 16'h6949;
      6'd24: return 16'h6F4F;
      6'd25: return 16'h7050;
      6'd26: return 16'h5B7B;
      6'd27: return 16'h5D7D;
      6'd28: return 16'h0A0A;
      6'd30: return 16'h6141;
      6'd31: return 16'h7353;
      6'd32: return 16'h6444;
      6'd33: return 16'h6646;
      6'd34: return 16'h6747;
      6'd35: return 16'h6848;
      6'd36: return 16'h6A4A;
      6'd37: return 16'h6B4B;
      6'd38: return 16'h6C4C;
      6'd39: return 16'h3B3A;
      6'd40: return 16'h2722;
      6'd41: return 16'h607E;
      6'd43: return 16'h5C7C;
      6'd44: return 16'h7A5A;
      6'd45: return 16'h7858;
      6'd46: return 16'h6343;
      6'd47: return 16'h7656;
      6'd48: return 16'h6242;
      6'd49: return 16'h6E4E;
      6'd50: return 16'h6D4D;
      6'd51: return 16'h2C3C;
      6'd52: return 16'h2E3E;
      6'd53: return 16'h2F3F;
      6'd55: return 16'h2A2A;
      6'd57: return 16'h2020;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [7:0] e0_key(input logic [7:0] sc);
    case (sc)
      8'h48:   return 8'h81;
      8'h50:   return 8'h82;
      8'h4B:   return 8'h83;
      8'h4D:   return 8'h84;
      8'h53:   return 8'h85;
      8'h47:   return 8'h86;
      8'h4F:   return 8'h87;
      8'h1C:   return 8'h0A;
      8'h35:   return "/";
      8'h4E:   return "+";
      default: return 8'h00;
    endcase
  endfunction

  function automatic int ring_step(input int p);
    return (p + 1) % RING_DEPTH;
  endfunction

  // Send a key to the app queue, or push it into the shell ring (no result)
  function automatic bit route_key(input logic [7:0] c, input scan_beat_t b,
                                   output key_event_t ev);
    int nxt;
    ev = '0;
    if (gui_on && (b.switcher_open || !b.terminal_focused)) begin
      ev.kind = KIND_APP;
      ev.key_code = c;
      ev.ring_not_empty = (wr_ptr != rd_ptr);
      return 1'b1;
    end
    nxt = ring_step(wr_ptr);
    if (nxt != rd_ptr) begin
      ring_copy[wr_ptr] = c;
      wr_ptr = nxt;
    end else begin
      keys_dropped++;
    end
    return 1'b0;
  endfunction

  function automatic bit translate_scancode(input scan_beat_t b, output key_event_t ev);
    logic [7:0] sc;
    logic [7:0] c;
    logic [7:0] made;
    logic [15:0] pair;
    sc = b.scan_byte;
    ev = '0;
    if (b.action == ACT_READ) begin
      ev.kind = KIND_READ;
      if (wr_ptr != rd_ptr) begin
        ev.key_code = ring_copy[rd_ptr];
        ev.read_hit = 1'b1;
        rd_ptr = ring_step(rd_ptr);
      end
      ev.ring_not_empty = (wr_ptr != rd_ptr);
      return 1'b1;
    end
    if (ext_armed) begin
      ext_armed = 1'b0;
      if (sc[7]) return 1'b0;
      c = e0_key(sc);
      if (c == 8'h00) return 1'b0;
      return route_key(c, b, ev);
    end
    if (sc == SC_EXT_PREFIX) begin
      ext_armed = 1'b1;
      return 1'b0;
    end
    if (sc[7]) begin
      made = sc & ~BREAK_FLAG;
      if (made == SC_LSHIFT || made == SC_RSHIFT) shift_down = 1'b0;
      else if (made == SC_CTRL) ctrl_down = 1'b0;
      else if (made == SC_ALT) alt_down = 1'b0;
      return 1'b0;
    end
    if (sc == SC_LSHIFT || sc == SC_RSHIFT) begin
      shift_down = 1'b1;
      return 1'b0;
    end
    if (sc == SC_CTRL) begin
      ctrl_down = 1'b1;
      return 1'b0;
    end
    if (sc == SC_ALT) begin
      alt_down = 1'b1;
      return 1'b0;
    end
    if (sc == SC_TAB && alt_down) return route_key(KEY_ALT_TAB, b, ev);
    if (sc == SC_T && alt_down) begin
      ev.kind = KIND_FOCUS;
      ev.ring_not_empty = (wr_ptr != rd_ptr);
      return 1'b1;
    end
    if (sc == SC_CAPS) begin
      caps_lit = !caps_lit;
      return 1'b0;
    end
    c = 8'h00;
    if (sc < 8'd64) begin
      pair = us_key_pair(sc[5:0]);
      c = shift_down ? pair[7:0] : pair[15:8];
    end
    // caps flips letter case, and flips it back when shift is also down
    if (caps_lit && c >= "a" && c <= "z") c = c - CASE_OFFSET;
    else if (caps_lit && shift_down && c >= "A" && c <= "Z") c = c + CASE_OFFSET;
    if (c == 8'h00) return 1'b0;
    if (ctrl_down && c >= "a" && c <= "z") c = c - "a" + 8'd1;
    else if (ctrl_down && c >= "A" && c <= "Z") c = c - "A" + 8'd1;
    return route_key(c, b, ev);
  endfunction

  // Sample both channels at the rising edge: check first, then predict
  always @(posedge clk) begin
    key_event_t got, want;
    key_event_t ev;
    in_fired = 1'b0;
    out_fired = 1'b0;
    if (!rst_n) begin
      gui_on = 1'b0;
      shift_down = 1'b0;
      ctrl_down = 1'b0;
      alt_down = 1'b0;
      caps_lit = 1'b0;
      ext_armed = 1'b0;
      wr_ptr = 0;
      rd_ptr = 0;
    end else begin
      if (cfg_valid && cfg_ready) gui_on = cfg_data;
      if (out_valid && !out_stall) begin
        out_fired = 1'b1;
        events_seen++;
        got = '{out_kind, out_key_code, out_read_hit, out_ring_not_empty};
        if (events_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: kind %0d key %02h hit %0b nonempty %0b",
                     got.kind, got.key_code, got.read_hit, got.ring_not_empty);
        end else begin
          want = events_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch (exp/act): kind %0d/%0d key %02h/%02h ",
                        "hit %0b/%0b nonempty %0b/%0b"},
                       want.kind, got.kind, want.key_code, got.key_code,
                       want.read_hit, got.read_hit,
                       want.ring_not_empty, got.ring_not_empty);
          end
          case (want.kind)
            KIND_APP:   app_keys++;
            KIND_FOCUS: focus_events++;
            default:    if (want.read_hit) read_hits++; else read_misses++;
          endcase
        end
      end
      if (in_valid && !in_stall) begin
        in_fired = 1'b1;
        beats_taken++;
        if (translate_scancode('{in_action, in_scan_byte, in_switcher_open,
                                 in_terminal_focused}, ev))
          events_due.push_back(ev);
      end
    end
  end

  // Sender: hold a stalled beat, otherwise wait the drawn gap and present the next
  always @(negedge clk) begin
    scan_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else if (!in_valid || in_fired) begin
      if (in_fired) send_wait = $urandom_range(idle_max, 0);
      if (send_wait == 0 && pending_scans.size() != 0) begin
        nxt = pending_scans.pop_front();
        in_valid <= 1'b1;
        in_action <= nxt.action;
        in_scan_byte <= nxt.scan_byte;
        in_switcher_open <= nxt.switcher_open;
        in_terminal_focused <= nxt.terminal_focused;
      end else begin
        in_valid <= 1'b0;
        if (send_wait != 0) send_wait--;
      end
    end
  end

  // Receiver: stall a drawn number of cycles after each result beat
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_fired) recv_wait = $urandom_range(idle_max, 0);
      else if (recv_wait != 0) recv_wait--;
      out_stall <= hold_out || (recv_wait != 0);
    end
  end

  function automatic void queue_scan(input logic [7:0] sc, input bit sw = 1'b0,
                                     input bit tf = 1'b1);
    pending_scans.push_back('{ACT_SCAN, sc, sw, tf});
    planned++;
  endfunction

  function automatic void queue_any(input logic [7:0] sc);
    queue_scan(sc, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
  endfunction

  function automatic void queue_read();
    pending_scans.push_back('{ACT_READ, 8'($urandom_range(255, 0)),
                              1'($urandom_range(1, 0)), 1'($urandom_range(1, 0))});
    planned++;
  endfunction

  function automatic void queue_tap(input logic [7:0] sc);
    queue_any(sc);
    if ($urandom_range(1, 0)) queue_any(sc | BREAK_FLAG);
  endfunction

  function automatic logic [7:0] pick_make();
    return 8'($urandom_range(8'h39, 8'h01));
  endfunction

  // Mostly well-formed typing sessions with random keys, plus stray bytes
  function automatic void queue_session(input int n, input int read_pct);
    int start;
    int r;
    int k;
    logic [7:0] mod;
    start = planned;
    while (planned - start < n) begin
      r = $urandom_range(99, 0);
      if (r < read_pct) begin
        queue_read();
      end else begin
        r = $urandom_range(99, 0);
        if (r < 35) begin
          queue_tap(pick_make());
        end else if (r < 65) begin
          case ($urandom_range(3, 0))
            0: mod = SC_LSHIFT;
            1: mod = SC_RSHIFT;
            2: mod = SC_CTRL;
            default: mod = SC_ALT;
          endcase
          queue_any(mod);
          for (k = $urandom_range(3, 1); k > 0; k--) begin
            if (mod == SC_ALT && $urandom_range(1, 0))
              queue_tap($urandom_range(1, 0) ? SC_TAB : SC_T);
            else
              queue_tap(pick_make());
          end
          queue_any(mod | BREAK_FLAG);
        end else if (r < 72) begin
          queue_any(SC_CAPS);
          queue_any(SC_CAPS | BREAK_FLAG);
        end else if (r < 90) begin
          queue_any(SC_EXT_PREFIX);
          case ($urandom_range(3, 0))
            0, 1: queue_any(8'($urandom_range(8'h53, 8'h47)));
            2: queue_any($urandom_range(1, 0) ? 8'h1C : 8'h35);
            default: queue_any(8'($urandom_range(255, 0)));
          endcase
        end else begin
          queue_any(8'($urandom_range(255, 0)));
        end
      end
    end
  endfunction

  task automatic drain_and_wait();
    while (pending_scans.size() != 0 || in_valid || events_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_gui_mode(input bit on);
    drain_and_wait();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= on;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int k;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_gui_mode(1'b0);
    // Directed: empty read, shift, caps with and without shift, ctrl letter,
    // extended make and break, unmapped bytes, alt+tab and alt+t
    queue_read();
    queue_scan(8'h1E);
    queue_scan(SC_LSHIFT);
    queue_scan(8'h02);
    queue_scan(SC_LSHIFT | BREAK_FLAG);
    queue_scan(SC_CAPS);
    queue_scan(8'h10);
    queue_scan(SC_RSHIFT);
    queue_scan(8'h10);
    queue_scan(SC_RSHIFT | BREAK_FLAG);
    queue_scan(SC_CAPS);
    queue_scan(SC_CTRL);
    queue_scan(8'h2E);
    queue_scan(SC_CTRL | BREAK_FLAG);
    queue_scan(SC_EXT_PREFIX);
    queue_scan(8'h48);
    queue_scan(SC_EXT_PREFIX);
    queue_scan(8'hC8);
    queue_scan(8'h00);
    queue_scan(8'h7F);
    queue_scan(8'hFF);
    queue_scan(SC_ALT);
    queue_scan(SC_TAB);
    queue_scan(SC_T);
    queue_scan(SC_ALT | BREAK_FLAG);
    for (k = 0; k < 8; k++) queue_read();

    set_gui_mode(1'b1);
    queue_scan(8'h1E, 1'b1, 1'b1);
    queue_scan(8'h30, 1'b0, 1'b0);
    queue_scan(8'h30, 1'b0, 1'b1);
    queue_scan(SC_EXT_PREFIX, 1'b1, 1'b0);
    queue_scan(8'h01, 1'b1, 1'b0);
    queue_read();

    // Hold the result side off while beats keep coming, so the input stalls
    drain_and_wait();
    idle_max = 0;
    fork
      begin
        @(negedge clk);
        hold_out <= 1'b1;
        repeat (200) @(negedge clk);
        hold_out <= 1'b0;
      end
    join_none
    for (k = 0; k < 40; k++) begin
      if (k % 2) queue_read();
      else queue_scan(8'($urandom_range(8'h32, 8'h10)), 1'b1, 1'b0);
    end
    drain_and_wait();
    idle_max = IDLE_MAX;

    set_gui_mode(1'b0);
    queue_session(300, 25);
    // Flood the shell ring past full, then read it back
    queue_scan(SC_CTRL | BREAK_FLAG);
    queue_scan(SC_ALT | BREAK_FLAG);
    for (k = 0; k < 280; k++) queue_any(8'($urandom_range(8'h32, 8'h10)));
    queue_session(300, 60);

    set_gui_mode(1'b1);
    queue_session(250, 25);

    set_gui_mode(1'b0);
    idle_max = 0;
    queue_session(150, 30);

    set_gui_mode(1'b1);
    queue_session(100, 20);
    idle_max = IDLE_MAX;

    drain_and_wait();
    $display("Sent %0d beats across gui_mode settings 0 and 1; ring flood dropped %0d keys",
             beats_taken, keys_dropped);
    $display("Checked %0d results: %0d app keys, %0d focus, %0d read hits, %0d empty reads",
             events_seen, app_keys, focus_events, read_hits, read_misses);
    if (mismatches == 0 && events_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results still due", mismatches, events_due.size());
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still due", events_due.size());
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sckt_pkg.sv
rtl/core/scancode_to_key_translator_core.sv
test/tb_scancode_to_key_translator_core.sv
